@@ sv/qte_pkg.sv @@
package qte_pkg;

    // Block parameters
    localparam int ANGLE_BITS     = 24;
    localparam int QUAT_FRAC_BITS = 30;
    localparam int CORDIC_STEPS   = 24;

    // Derived widths and counts
    localparam int COMP_W       = 32;
    localparam int VEC_W        = 36;
    localparam int ANG_W        = 34;
    localparam int SQRT_STEPS   = 31;
    localparam int IDX_W        = 5;
    localparam int OUT_SHIFT    = 32 - ANGLE_BITS;
    localparam int PROD_SHIFT   = 60 - 2 * QUAT_FRAC_BITS;
    localparam int FRONT_STAGES = 5;
    localparam int PIPE_STAGES  = FRONT_STAGES + SQRT_STEPS + 1 + CORDIC_STEPS;

    // Configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GIMBAL_THRESHOLD = 1'b1;
    localparam logic [30:0] THRESH_RESET = 31'd1073731087;

    // Lanes of the CORDIC cells
    localparam int LANE_HEAD  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_BANK  = 2;

    localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(1) << 30;
    localparam logic signed [ANG_W:0] ROUND_HALF = ((ANG_W + 1)'(1) << OUT_SHIFT) >> 1;

    // atan(2^-i), units of pi/2^31
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] heading_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] bank_angle;
        logic                         gimbal_lock;
    } euler_t;

    // Operands that ride alongside the square root
    typedef struct packed {
        logic signed [31:0]      sp;
        logic                    lock;
        logic signed [VEC_W-1:0] hy;
        logic signed [VEC_W-1:0] hx;
        logic signed [VEC_W-1:0] by;
        logic signed [VEC_W-1:0] bx;
    } side_t;

    typedef struct packed {
        logic [60:0] rem;
        logic [61:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } vec_t;

    typedef vec_t [2:0] vec3_t;

    typedef struct packed {
        vec3_t              lane;
        logic               lock;
        logic signed [31:0] sp;
    } cordic_t;

    // Move the vector into the right half plane
    function automatic vec_t prerot(input logic signed [VEC_W-1:0] y,
                                    input logic signed [VEC_W-1:0] x);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI;
            end
            else
            begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI;
            end
        end
        return v;
    endfunction

    // pi/2^31 units to output units, round half up
    function automatic logic [ANGLE_BITS-1:0] to_angle(input logic signed [ANG_W-1:0] z);
        logic signed [ANG_W:0] t;
        t = {z[ANG_W-1], z} + ROUND_HALF;
        return t[OUT_SHIFT +: ANGLE_BITS];
    endfunction

endpackage

@@ sv/qte_in_if.sv @@
interface qte_in_if import qte_pkg::*; ();
    logic  valid;
    logic  ready;
    quat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/qte_out_if.sv @@
interface qte_out_if import qte_pkg::*; ();
    logic   valid;
    logic   ready;
    euler_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/qte_front.sv @@
module qte_front import qte_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  quat_t       q_in,
    input  logic        inverse_mode,
    input  logic [30:0] gimbal_threshold,
    output logic [60:0] rad,
    output side_t       side_out
);

    localparam logic signed [COMP_W-1:0] COMP_LIM = COMP_W'(1) << QUAT_FRAC_BITS;
    localparam logic signed [65:0] HALF_Q60 = 66'sd1 <<< 59;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1 <<< 30;
    localparam logic [60:0]        ONE_Q60  = 61'd1 << 60;

    logic signed [COMP_W-1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [COMP_W-1:0] w_next, x_next, y_next, z_next;
    logic signed [63:0] wx_reg, yz_reg, wy_reg, xz_reg, xx_reg, yy_reg, zz_reg, xy_reg, wz_reg;
    side_t       side3_reg, side4_reg, side5_reg, side3_next;
    logic [30:0] mag_reg, mag_next;
    logic [60:0] sq_reg, rad_reg;
    logic [61:0] sq_full;

    function automatic logic signed [COMP_W-1:0] sat(input logic signed [COMP_W-1:0] v);
        if (v > COMP_LIM)
            return COMP_LIM;
        else if (v < -COMP_LIM)
            return -COMP_LIM;
        else
            return v;
    endfunction

    function automatic logic signed [63:0] prod(input logic signed [COMP_W-1:0] a,
                                                input logic signed [COMP_W-1:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p <<< PROD_SHIFT;
    endfunction

    function automatic logic signed [VEC_W-1:0] q30(input logic signed [65:0] v);
        logic signed [65:0] s;
        s = v >>> 30;
        return s[VEC_W-1:0];
    endfunction

    // Saturate components, negate w when inverse (the same rotation as the conjugate)
    always_comb
    begin
        w_next = sat(q_in.quat_w);
        x_next = sat(q_in.quat_x);
        y_next = sat(q_in.quat_y);
        z_next = sat(q_in.quat_z);
        if (inverse_mode)
            w_next = -w_next;
    end

    // sin pitch, lock decision, atan2 operands
    always_comb
    begin
        logic signed [65:0] d;
        logic signed [65:0] spw;
        logic signed [33:0] spn;
        d   = 66'(wx_reg) - 66'(yz_reg);
        spw = d >>> 29;
        if (spw > 66'(ONE_Q30))
            spn = ONE_Q30;
        else if (spw < -66'(ONE_Q30))
            spn = -ONE_Q30;
        else
            spn = spw[33:0];
        side3_next.sp   = spn[31:0];
        mag_next        = spn < 0 ? 31'(-spn) : 31'(spn);
        side3_next.lock = mag_next > gimbal_threshold;
        if (side3_next.lock)
        begin
            side3_next.hy = q30(66'(wy_reg) - 66'(xz_reg));
            side3_next.hx = q30(HALF_Q60 - 66'(yy_reg) - 66'(zz_reg));
        end
        else
        begin
            side3_next.hy = q30(66'(xz_reg) + 66'(wy_reg));
            side3_next.hx = q30(HALF_Q60 - 66'(xx_reg) - 66'(yy_reg));
        end
        side3_next.by = q30(66'(xy_reg) + 66'(wz_reg));
        side3_next.bx = q30(HALF_Q60 - 66'(xx_reg) - 66'(zz_reg));
    end

    assign sq_full = mag_reg * mag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= w_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            wx_reg    <= prod(w_reg, x_reg);
            yz_reg    <= prod(y_reg, z_reg);
            wy_reg    <= prod(w_reg, y_reg);
            xz_reg    <= prod(x_reg, z_reg);
            xx_reg    <= prod(x_reg, x_reg);
            yy_reg    <= prod(y_reg, y_reg);
            zz_reg    <= prod(z_reg, z_reg);
            xy_reg    <= prod(x_reg, y_reg);
            wz_reg    <= prod(w_reg, z_reg);
            side3_reg <= side3_next;
            mag_reg   <= mag_next;
            sq_reg    <= sq_full[60:0];
            side4_reg <= side3_reg;
            rad_reg   <= ONE_Q60 - sq_reg;
            side5_reg <= side4_reg;
        end
    end

    assign rad      = rad_reg;
    assign side_out = side5_reg;

endmodule

@@ sv/qte_sqrt_cell.sv @@
module qte_sqrt_cell import qte_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [IDX_W-1:0] idx,
    input  sqrt_t            s_in,
    input  side_t            side_in,
    output sqrt_t            s_out,
    output side_t            side_out
);

    sqrt_t s_reg, s_next;
    side_t side_reg;

    // One result bit: trial subtract of root plus 4^(30-idx)
    always_comb
    begin
        logic [61:0] bitv;
        logic [61:0] trial;
        bitv  = 62'(1) << (60 - 2 * int'(idx));
        trial = s_in.root + bitv;
        s_next = s_in;
        if ({1'b0, s_in.rem} >= trial)
        begin
            s_next.rem  = s_in.rem - trial[60:0];
            s_next.root = (s_in.root >> 1) + bitv;
        end
        else
        begin
            s_next.root = s_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= s_next;
            side_reg <= side_in;
        end
    end

    assign s_out    = s_reg;
    assign side_out = side_reg;

endmodule

@@ sv/qte_cordic_cell.sv @@
module qte_cordic_cell import qte_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [IDX_W-1:0] idx,
    input  cordic_t          c_in,
    output cordic_t          c_out
);

    cordic_t c_reg, c_next;

    // One vectoring micro-rotation on each lane
    always_comb
    begin
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic signed [ANG_W-1:0] at;
        c_next = c_in;
        at = ANG_W'(ATAN_TAB[idx]);
        for (int k = 0; k < 3; k++)
        begin
            dx = c_in.lane[k].x >>> idx;
            dy = c_in.lane[k].y >>> idx;
            if (c_in.lane[k].y < 0)
            begin
                c_next.lane[k].x = c_in.lane[k].x - dy;
                c_next.lane[k].y = c_in.lane[k].y + dx;
                c_next.lane[k].z = c_in.lane[k].z - at;
            end
            else
            begin
                c_next.lane[k].x = c_in.lane[k].x + dy;
                c_next.lane[k].y = c_in.lane[k].y - dx;
                c_next.lane[k].z = c_in.lane[k].z + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c_reg <= c_next;
    end

    assign c_out = c_reg;

endmodule

@@ sv/quaternion_to_euler_angles_top.sv @@
// Quaternion to heading/pitch/bank converter. Takes one quaternion per cycle
// while the pipeline is not held, and passes each request through 5 operand
// stages, a 31-cell square-root chain for cos pitch, one quadrant stage, a
// 24-cell CORDIC chain that runs heading, pitch and bank side by side, and
// the output register. Requests keep flowing while a result waits, until
// the next result reaches the end of the pipeline; then the whole pipeline
// holds. Angles: 2^(ANGLE_BITS-1) is pi. The user must write configuration
// registers only while the converter is empty; the block does not enforce this.
module quaternion_to_euler_angles_top import qte_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    qte_in_if.sink                quat_in,
    qte_out_if.source             euler_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                   inverse_mode_reg;
    logic [30:0]            gimbal_threshold_reg;
    logic [PIPE_STAGES-1:0] valid_reg;
    logic                   out_valid_reg, out_valid_next;
    euler_t                 out_reg, out_next;
    logic                   adv;
    logic [60:0]            rad;
    side_t                  front_side;
    sqrt_t                  sq_d   [SQRT_STEPS+1];
    side_t                  side_d [SQRT_STEPS+1];
    cordic_t                cord_d [CORDIC_STEPS+1];
    cordic_t                prep_reg, prep_next;

    // Whole pipeline moves unless a blocked result has another finished one behind it
    assign adv           = !(out_valid_reg && !euler_out.ready && valid_reg[PIPE_STAGES-1]);
    assign quat_in.ready = adv;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_mode_reg     <= 1'b0;
            gimbal_threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_INVERSE_MODE)
                inverse_mode_reg <= cfg_data[0];
            else if (cfg_index == CFG_GIMBAL_THRESHOLD)
                gimbal_threshold_reg <= cfg_data[30:0];
        end
    end

    qte_front u_front
    (
        .clk              (clk),
        .en               (adv),
        .q_in             (quat_in.data),
        .inverse_mode     (inverse_mode_reg),
        .gimbal_threshold (gimbal_threshold_reg),
        .rad              (rad),
        .side_out         (front_side)
    );

    // Square root chain: cos pitch = sqrt(1 - sp^2)
    assign sq_d[0].rem  = rad;
    assign sq_d[0].root = '0;
    assign side_d[0]    = front_side;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        qte_sqrt_cell u_cell
        (
            .clk      (clk),
            .en       (adv),
            .idx      (IDX_W'(i)),
            .s_in     (sq_d[i]),
            .side_in  (side_d[i]),
            .s_out    (sq_d[i+1]),
            .side_out (side_d[i+1])
        );
    end

    // Quadrant correction for the three vectors
    always_comb
    begin
        side_t s;
        s = side_d[SQRT_STEPS];
        prep_next.lane[LANE_HEAD]  = prerot(s.hy, s.hx);
        prep_next.lane[LANE_PITCH] = prerot(VEC_W'(s.sp),
                                            VEC_W'(sq_d[SQRT_STEPS].root[30:0]));
        prep_next.lane[LANE_BANK]  = prerot(s.by, s.bx);
        prep_next.lock             = s.lock;
        prep_next.sp               = s.sp;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            prep_reg <= prep_next;
    end

    assign cord_d[0] = prep_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        qte_cordic_cell u_cell
        (
            .clk   (clk),
            .en    (adv),
            .idx   (IDX_W'(i)),
            .c_in  (cord_d[i]),
            .c_out (cord_d[i+1])
        );
    end

    // Result formatting
    always_comb
    begin
        cordic_t c;
        logic signed [ANG_W-1:0] hz, pz, bz;
        c  = cord_d[CORDIC_STEPS];
        hz = c.lane[LANE_HEAD].zero  ? '0 : c.lane[LANE_HEAD].z;
        pz = c.lane[LANE_PITCH].zero ? '0 : c.lane[LANE_PITCH].z;
        bz = c.lane[LANE_BANK].zero  ? '0 : c.lane[LANE_BANK].z;
        out_next.heading_angle = to_angle(hz);
        out_next.gimbal_lock   = c.lock;
        if (c.lock)
        begin
            out_next.pitch_angle = to_angle(ANG_W'(c.sp));
            out_next.bank_angle  = '0;
        end
        else
        begin
            out_next.pitch_angle = to_angle(pz);
            out_next.bank_angle  = to_angle(bz);
        end
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (euler_out.ready)
            out_valid_next = 1'b0;
        if (adv && valid_reg[PIPE_STAGES-1])
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
                valid_reg <= {valid_reg[PIPE_STAGES-2:0], quat_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_reg[PIPE_STAGES-1])
            out_reg <= out_next;
    end

    assign euler_out.valid = out_valid_reg;
    assign euler_out.data  = out_reg;

endmodule
